[rtl/core/nscrc8_pkg.sv]
// ----------------------------------------------------------------------------
// Nibble sum / CRC-8 checker package
// Types, frame format codes and CRC helpers shared by the checker.
// ----------------------------------------------------------------------------
package nscrc8_pkg;

  // Frame format codes, sampled on the first nibble of a frame.
  localparam logic [1:0] FmtLong    = 2'd0;
  localparam logic [1:0] FmtGas     = 2'd1;
  localparam logic [1:0] FmtShort   = 2'd2;
  localparam logic [1:0] FmtUnknown = 2'd3;

  // Number of data nibbles covered by the sum.
  localparam logic [4:0] LenLong  = 5'd15;
  localparam logic [4:0] LenShort = 5'd12;

  // Nibble positions that the CRC skips for the weather formats.
  localparam logic [4:0] SkipFirst  = 5'd5;
  localparam logic [4:0] SkipSecond = 5'd6;

  localparam logic [7:0] CrcPoly      = 8'h07;
  localparam logic [7:0] CrcTop       = 8'h80;
  localparam logic [7:0] CrcInitLong  = 8'h3C;
  localparam logic [7:0] CrcInitShort = 8'hD6;
  localparam logic [7:0] CrcInitNone  = 8'h00;

  typedef struct packed {
    logic [3:0] nibble;
    logic       frame_start;
    logic [1:0] format;
  } in_item_t;

  typedef struct packed {
    logic       check_ok;
    logic [7:0] computed_crc;
    logic [7:0] computed_sum;
  } out_item_t;

  // Four CRC shift steps, one nibble's worth.
  function automatic logic [7:0] crc_shift4(input logic [7:0] crc);
    logic [7:0] v;
    v = crc;
    for (int k = 0; k < 4; k++) begin
      if ((v & CrcTop) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

[rtl/core/nibble_sum_crc8_checker.sv]
// ----------------------------------------------------------------------------
// Nibble sum / CRC-8 frame checker
// Keeps an 8-bit sum and a CRC-8 (poly 0x07) over a nibble stream and
// reports the check result on the nibble that completes each frame.
// ----------------------------------------------------------------------------
// Results: the last nibble of a frame passes the input register, then the
//   result register, before its check result is valid.
// Throughput: one nibble per cycle unless the output stalls; the sum add and the
//   four unrolled CRC shifts sit between the input register and the frame state registers.
// Reset: the block comes up idle, format unknown, and ignores nibbles until
//   one arrives with frame_start set.
module nibble_sum_crc8_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  nscrc8_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output nscrc8_pkg::out_item_t out_data_o
);

  // Input register stage.
  logic                 s1_valid_q, s1_valid_d;
  nscrc8_pkg::in_item_t s1_data_q;
  logic                 s1_adv, s1_fire, in_xfer;

  // Frame state.
  logic [4:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] crc_q, crc_d;
  logic [1:0] fmt_q, fmt_d;
  logic [7:0] rsum_q, rsum_d;
  logic [7:0] rcrc_q, rcrc_d;
  logic       done_q, done_d;

  // State as seen by the current nibble, after a possible restart.
  logic [4:0] cnt_e;
  logic [7:0] sum_e, crc_e, rsum_e, rcrc_e;
  logic [1:0] fmt_e;
  logic       done_e;
  logic [4:0] len;
  logic       skips;
  logic [7:0] nib8;
  logic [7:0] fin_crc;

  logic                  res_vld;
  nscrc8_pkg::out_item_t res;

  logic                  out_valid_q, out_valid_d;
  nscrc8_pkg::out_item_t out_data_q;

  assign s1_adv     = ~out_valid_q | ~out_stall_i;
  assign s1_fire    = s1_valid_q & s1_adv;
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  always_comb begin
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    nib8 = {4'b0000, s1_data_q.nibble};

    if (s1_data_q.frame_start) begin
      fmt_e  = s1_data_q.format;
      cnt_e  = 5'd0;
      sum_e  = 8'h00;
      rsum_e = 8'h00;
      rcrc_e = 8'h00;
      done_e = 1'b0;
      if (s1_data_q.format == nscrc8_pkg::FmtLong) begin
        crc_e = nscrc8_pkg::CrcInitLong;
      end else if (s1_data_q.format == nscrc8_pkg::FmtShort) begin
        crc_e = nscrc8_pkg::CrcInitShort;
      end else begin
        crc_e = nscrc8_pkg::CrcInitNone;
      end
    end else begin
      fmt_e  = fmt_q;
      cnt_e  = cnt_q;
      sum_e  = sum_q;
      crc_e  = crc_q;
      rsum_e = rsum_q;
      rcrc_e = rcrc_q;
      done_e = done_q;
    end

    len   = (fmt_e == nscrc8_pkg::FmtShort) ? nscrc8_pkg::LenShort : nscrc8_pkg::LenLong;
    skips = (fmt_e == nscrc8_pkg::FmtLong) || (fmt_e == nscrc8_pkg::FmtShort);
    fin_crc = nscrc8_pkg::crc_shift4(crc_e);

    fmt_d  = fmt_e;
    cnt_d  = cnt_e;
    sum_d  = sum_e;
    crc_d  = crc_e;
    rsum_d = rsum_e;
    rcrc_d = rcrc_e;
    done_d = done_e;

    res_vld          = 1'b0;
    res.check_ok     = 1'b0;
    res.computed_crc = fin_crc;
    res.computed_sum = sum_e;

    if (!done_e) begin
      cnt_d = cnt_e + 5'd1;
      priority if (cnt_e < len) begin
        sum_d = sum_e + nib8;
        if (!(skips && (cnt_e == nscrc8_pkg::SkipFirst ||
                        cnt_e == nscrc8_pkg::SkipSecond))) begin
          crc_d = nscrc8_pkg::crc_shift4(crc_e ^ nib8);
        end
      end else if (cnt_e == len) begin
        rsum_d = nib8;
      end else if (cnt_e == len + 5'd1) begin
        rsum_d = {s1_data_q.nibble, rsum_e[3:0]};
      end else if (cnt_e == len + 5'd2) begin
        rcrc_d = nib8;
      end else begin
        // Last nibble: high half of the received CRC closes the frame.
        rcrc_d       = {s1_data_q.nibble, rcrc_e[3:0]};
        res_vld      = 1'b1;
        res.check_ok = (fmt_e != nscrc8_pkg::FmtUnknown) && (rsum_e == sum_e) &&
                       (rcrc_d == fin_crc);
        done_d       = 1'b1;
        cnt_d        = 5'd0;
      end
    end
  end

  always_comb begin
    if (s1_fire && res_vld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= 5'd0;
      sum_q       <= 8'h00;
      crc_q       <= 8'h00;
      fmt_q       <= nscrc8_pkg::FmtUnknown;
      rsum_q      <= 8'h00;
      rcrc_q      <= 8'h00;
      done_q      <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        cnt_q  <= cnt_d;
        sum_q  <= sum_d;
        crc_q  <= crc_d;
        fmt_q  <= fmt_d;
        rsum_q <= rsum_d;
        rcrc_q <= rcrc_d;
        done_q <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (s1_fire && res_vld) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An idle checker always waits at the first nibble position.
  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == 5'd0)
    else $error("nibble count not zero while idle");

  // The nibble position never runs past the last nibble of the longest frame.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= nscrc8_pkg::LenLong + 5'd3)
    else $error("nibble count out of range");

  // Producing a result closes the frame.
  a_result_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res_vld) |=> done_q && out_valid_o)
    else $error("result produced without closing the frame");

  // A stall toward the source only comes from a held nibble.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without a pending nibble");

endmodule

[test/nscrc8_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble sum / CRC-8 checker test package
// Frame tracker that follows the nibble stream, predicts each frame's check
// result and compares it with what the checker reports.
// ----------------------------------------------------------------------------
package nscrc8_tb_pkg;
  import nscrc8_pkg::*;

  class crc8_frame_tracker;
    logic [4:0]  pos;
    logic [7:0]  sum_acc;
    logic [7:0]  crc_acc;
    logic [7:0]  rx_sum;
    logic [7:0]  rx_crc;
    logic [1:0]  fmt;
    logic        idle;
    out_item_t   pending_checks[$];
    int unsigned mismatches;

    function new();
      pos        = '0;
      sum_acc    = '0;
      crc_acc    = '0;
      rx_sum     = '0;
      rx_crc     = '0;
      fmt        = FmtUnknown;
      idle       = 1'b1;
      mismatches = 0;
    endfunction

    // One nibble's worth of CRC-8 shifting, MSB first.
    static function logic [7:0] crc8_shift_nibble(input logic [7:0] value);
      logic [7:0] r;
      r = value;
      repeat (4) begin
        r = r[7] ? ({r[6:0], 1'b0} ^ CrcPoly) : {r[6:0], 1'b0};
      end
      return r;
    endfunction

    function int pending();
      return pending_checks.size();
    endfunction

    // Called for every accepted input transfer.
    function void note_nibble(input in_item_t it);
      logic [4:0] data_len;
      logic       skips;
      out_item_t  frame_check;
      if (it.frame_start) begin
        fmt     = it.format;
        pos     = '0;
        sum_acc = '0;
        rx_sum  = '0;
        rx_crc  = '0;
        idle    = 1'b0;
        case (it.format)
          FmtLong:  crc_acc = CrcInitLong;
          FmtShort: crc_acc = CrcInitShort;
          default:  crc_acc = CrcInitNone;
        endcase
      end
      if (idle) return;
      data_len = (fmt == FmtShort) ? LenShort : LenLong;
      skips    = (fmt == FmtLong) || (fmt == FmtShort);
      if (pos < data_len) begin
        sum_acc = sum_acc + {4'h0, it.nibble};
        if (!(skips && (pos == SkipFirst || pos == SkipSecond))) begin
          crc_acc = crc8_shift_nibble(crc_acc ^ {4'h0, it.nibble});
        end
      end else if (pos == data_len) begin
        rx_sum = {4'h0, it.nibble};
      end else if (pos == data_len + 5'd1) begin
        rx_sum[7:4] = it.nibble;
      end else if (pos == data_len + 5'd2) begin
        rx_crc = {4'h0, it.nibble};
      end else begin
        // Last nibble of the frame: the CRC gets its closing shifts here.
        rx_crc[7:4]              = it.nibble;
        frame_check.computed_crc = crc8_shift_nibble(crc_acc);
        frame_check.computed_sum = sum_acc;
        frame_check.check_ok     = (fmt != FmtUnknown) && (rx_sum == sum_acc) &&
                                   (rx_crc == frame_check.computed_crc);
        pending_checks.push_back(frame_check);
        idle = 1'b1;
        pos  = '0;
        return;
      end
      pos = pos + 5'd1;
    endfunction

    // Called for every accepted output transfer.
    function void check_result(input out_item_t got);
      out_item_t want;
      if (pending_checks.size() == 0) begin
        $error("result with no frame pending: check_ok %0d crc 0x%02h sum 0x%02h",
               got.check_ok, got.computed_crc, got.computed_sum);
        mismatches++;
        return;
      end
      want = pending_checks.pop_front();
      if (got.check_ok !== want.check_ok) begin
        $error("check_ok mismatch: expected %0d, actual %0d", want.check_ok, got.check_ok);
        mismatches++;
      end
      if (got.computed_crc !== want.computed_crc) begin
        $error("computed_crc mismatch: expected 0x%02h, actual 0x%02h",
               want.computed_crc, got.computed_crc);
        mismatches++;
      end
      if (got.computed_sum !== want.computed_sum) begin
        $error("computed_sum mismatch: expected 0x%02h, actual 0x%02h",
               want.computed_sum, got.computed_sum);
        mismatches++;
      end
    endfunction
  endclass

endpackage

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble sum / CRC-8 checker testbench
// Sends whole, corrupted and cut-off frames of every format mixed with stray
// nibbles, under random sender gaps and receiver stalls, and checks every
// reported frame result against a cycle-independent prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import nscrc8_pkg::*;
  import nscrc8_tb_pkg::*;

  typedef enum int {
    FlawNone,
    FlawSum,
    FlawCrc,
    FlawCut
  } frame_flaw_e;

  localparam int unsigned CycleLimit  = 400000;
  localparam int          HoldCycles  = 150;
  localparam int          DrainCycles = 8;
  localparam int          PhaseItems  = 270;
  localparam int          TotalItems  = 800;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int unsigned sender_pct;
  int unsigned recv_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned cycle_count;
  int          nibbles_sent;

  crc8_frame_tracker tracker;

  nibble_sum_crc8_checker DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("nibble_sum_crc8_checker regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_stall   <= 1'b0;
    hold_served = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        repeat (HoldCycles) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Outputs are sampled mid-cycle, where everything is settled for the next edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_data);
    end
  end

  task automatic send_nibble(input in_item_t it);
    while ($urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    // The transfer completes at the coming edge.
    tracker.note_nibble(it);
    @(posedge clk);
  endtask

  function automatic logic [3:0] pick_nibble();
    case ($urandom_range(7))
      0:       return 4'h0;
      1:       return 4'hF;
      default: return 4'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_format();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 3) return FmtLong;
    if (r < 6) return FmtGas;
    if (r < 9) return FmtShort;
    return FmtUnknown;
  endfunction

  // Builds a frame with valid check fields, then damages it as asked.
  task automatic send_frame(input logic [1:0] fmt, input frame_flaw_e flaw,
                            input bit alternate);
    logic [3:0] nibs[$];
    logic [3:0] nib;
    logic [7:0] sum;
    logic [7:0] crc;
    logic       skips;
    int         data_len;
    int         send_len;
    in_item_t   it;
    data_len = (fmt == FmtShort) ? LenShort : LenLong;
    skips    = (fmt == FmtLong) || (fmt == FmtShort);
    sum      = '0;
    case (fmt)
      FmtLong:  crc = CrcInitLong;
      FmtShort: crc = CrcInitShort;
      default:  crc = CrcInitNone;
    endcase
    for (int i = 0; i < data_len; i++) begin
      nib = alternate ? ((i % 2 == 1) ? 4'hF : 4'h0) : pick_nibble();
      nibs.push_back(nib);
      sum = sum + {4'h0, nib};
      if (!(skips && (i == SkipFirst || i == SkipSecond))) begin
        crc = crc8_frame_tracker::crc8_shift_nibble(crc ^ {4'h0, nib});
      end
    end
    crc = crc8_frame_tracker::crc8_shift_nibble(crc);
    if (flaw == FlawSum) sum = sum ^ (8'h01 << $urandom_range(7));
    if (flaw == FlawCrc) crc = crc ^ (8'h01 << $urandom_range(7));
    nibs.push_back(sum[3:0]);
    nibs.push_back(sum[7:4]);
    nibs.push_back(crc[3:0]);
    nibs.push_back(crc[7:4]);
    send_len = nibs.size();
    if (flaw == FlawCut) send_len = $urandom_range(1, nibs.size() - 1);
    for (int i = 0; i < send_len; i++) begin
      it.nibble      = nibs[i];
      it.frame_start = (i == 0);
      // The format field only matters on the start nibble.
      it.format      = (i == 0) ? fmt : 2'($urandom);
      send_nibble(it);
      nibbles_sent++;
    end
  endtask

  task automatic send_noise();
    in_item_t it;
    repeat ($urandom_range(1, 6)) begin
      it.nibble      = 4'($urandom);
      it.frame_start = ($urandom_range(9) == 0);
      it.format      = 2'($urandom);
      send_nibble(it);
    end
  endtask

  task automatic run_random(input int upto);
    int unsigned r;
    while (nibbles_sent < upto) begin
      r = $urandom_range(99);
      if (r < 60)      send_frame(pick_format(), FlawNone, 1'b0);
      else if (r < 70) send_frame(pick_format(), FlawSum, 1'b0);
      else if (r < 80) send_frame(pick_format(), FlawCrc, 1'b0);
      else if (r < 90) send_frame(pick_format(), FlawCut, 1'b0);
      else             send_noise();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    tracker       = new();
    sender_pct    = 0;
    recv_pct      = 0;
    hold_requests = 0;
    nibbles_sent  = 0;
    rst_n         = 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stray nibbles while idle, starts that abandon partial frames, a cut-off
    // long frame, then a complete short frame of alternating extreme nibbles.
    it = '{nibble: 4'hF, frame_start: 1'b0, format: FmtGas};
    send_nibble(it);
    it = '{nibble: 4'h0, frame_start: 1'b0, format: FmtUnknown};
    send_nibble(it);
    it = '{nibble: 4'hA, frame_start: 1'b1, format: FmtGas};
    send_nibble(it);
    it = '{nibble: 4'h5, frame_start: 1'b1, format: FmtUnknown};
    send_nibble(it);
    send_frame(FmtLong, FlawCut, 1'b1);
    send_frame(FmtShort, FlawNone, 1'b1);
    wait_drained();

    sender_pct = 26;
    recv_pct   = 47;
    hold_requests++;
    nibbles_sent = 0;
    run_random(PhaseItems);
    wait_drained();

    sender_pct = 47;
    recv_pct   = 26;
    run_random(2 * PhaseItems);
    wait_drained();

    sender_pct = 0;
    recv_pct   = 0;
    run_random(TotalItems);
    wait_drained();

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("nibble_sum_crc8_checker regression: pass");
    end else begin
      $display("nibble_sum_crc8_checker regression: fail");
    end
    $finish;
  end

endmodule

[nibble_sum_crc8_checker.f]
rtl/core/nscrc8_pkg.sv
rtl/core/nibble_sum_crc8_checker.sv
test/nscrc8_tb_pkg.sv
test/tb_top.sv
